[sv/sorted_best_n_table_core_macros.svh]
// assertion macros for the sorted best-n table
`ifndef SORTED_BEST_N_TABLE_CORE_MACROS_SVH
`define SORTED_BEST_N_TABLE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SBNT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define SBNT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SBNT_ASSERT(lbl, prop, msg)
`define SBNT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[sv/sbnt_pkg.sv]
package sbnt_pkg;

    localparam int COST_W   = 32;
    localparam int HANDLE_W = 9;
    localparam int RANK_W   = 8;
    localparam int SUM_W    = 40;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef struct packed {
        logic                valid;
        logic [COST_W-1:0]   cost;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

endpackage

[sv/sbnt_cell.sv]
module sbnt_cell
    import sbnt_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [COST_W-1:0]   i_cost,
    input  logic [HANDLE_W-1:0] i_handle,
    input  t_entry            i_left,
    input  logic              i_left_gt,
    input  logic [RANK_W-1:0] i_rank_index,
    output t_entry            o_entry,
    output logic              o_gt,
    output logic [RANK_W-1:0] o_rank,
    output t_entry            o_rd
);

    localparam logic [RANK_W-1:0] IDX_LO = IDX[RANK_W-1:0];
    localparam bit READABLE = (IDX < (1 << RANK_W));

    t_entry r_entry;
    t_entry n_entry;
    logic   w_ins;
    logic   w_hit;

    // empty cells count as infinitely costly
    assign o_gt  = !r_entry.valid || (r_entry.cost > i_cost);
    assign w_ins = o_gt && !i_left_gt;

    always_comb begin
        n_entry = r_entry;
        if (i_en) begin
            if (i_left_gt) begin
                n_entry = i_left;
            end else if (o_gt) begin
                n_entry.valid  = 1'b1;
                n_entry.cost   = i_cost;
                n_entry.handle = i_handle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign w_hit   = READABLE && r_entry.valid && (i_rank_index == IDX_LO);
    assign o_entry = r_entry;
    assign o_rank  = w_ins ? IDX_LO : '0;
    assign o_rd    = w_hit ? r_entry : '0;

endmodule

[sv/sorted_best_n_table_core.sv]
// result: the request is registered, then its result is registered once the output is free
// requests: no new request is taken while the last one is busy in the single compare-and-shift pass
// through the cell chain; a waiting result stalls only that pass
// reset: synchronous, clears the cell valid bits, running sum and handshake state;
// no clearing pass over the table
`include "sorted_best_n_table_core_macros.svh"

module sorted_best_n_table_core
    import sbnt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_req_type,
    input  logic [COST_W-1:0]   i_candidate_cost,
    input  logic [HANDLE_W-1:0] i_candidate_handle,
    input  logic [RANK_W-1:0]   i_rank_index,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_accepted,
    output logic [RANK_W-1:0]   o_insert_rank,
    output logic                o_evicted_valid,
    output logic [HANDLE_W-1:0] o_evicted_handle,
    output logic                o_rank_valid,
    output logic [HANDLE_W-1:0] o_rank_handle,
    output logic [COST_W-1:0]   o_rank_cost,
    output logic [COST_W-1:0]   o_best_cost,
    output logic [COST_W-1:0]   o_worst_cost,
    output logic [SUM_W-1:0]    o_cost_sum
);

    logic                r_busy;
    logic                r_req_type;
    logic [COST_W-1:0]   r_cost;
    logic [HANDLE_W-1:0] r_handle;
    logic [RANK_W-1:0]   r_rank_index;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;
    logic [COST_W-1:0]   r_worst;
    logic [COST_W-1:0]   n_worst;
    logic [COST_W-1:0]   n_best;

    t_entry            w_entry [TABLE_DEPTH];
    logic              w_gt    [TABLE_DEPTH];
    logic [RANK_W-1:0] w_rank  [TABLE_DEPTH];
    t_entry            w_rd    [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_vld;

    logic              w_go;
    logic              w_full;
    logic              w_is_ins;
    logic              w_acc;
    logic              w_evict;
    logic              w_en;
    logic [RANK_W-1:0] w_rank_or;
    t_entry            w_rd_or;

    assign o_ready = !r_busy;
    assign w_go    = r_busy && (!o_valid || i_ready);

    assign w_full   = w_entry[TABLE_DEPTH-1].valid;
    assign w_is_ins = (r_req_type == REQ_INSERT);
    assign w_acc    = w_is_ins && (!w_full || w_gt[TABLE_DEPTH-1]);
    assign w_evict  = w_is_ins && w_full && w_gt[TABLE_DEPTH-1];
    assign w_en     = w_go && w_acc;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            sbnt_cell #(.IDX(g)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_en         (w_en),
                .i_cost       (r_cost),
                .i_handle     (r_handle),
                .i_left       ('0),
                .i_left_gt    (1'b0),
                .i_rank_index (r_rank_index),
                .o_entry      (w_entry[g]),
                .o_gt         (w_gt[g]),
                .o_rank       (w_rank[g]),
                .o_rd         (w_rd[g])
            );
        end else begin : g_body
            sbnt_cell #(.IDX(g)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_en         (w_en),
                .i_cost       (r_cost),
                .i_handle     (r_handle),
                .i_left       (w_entry[g-1]),
                .i_left_gt    (w_gt[g-1]),
                .i_rank_index (r_rank_index),
                .o_entry      (w_entry[g]),
                .o_gt         (w_gt[g]),
                .o_rank       (w_rank[g]),
                .o_rd         (w_rd[g])
            );
        end
        assign w_vld[g] = w_entry[g].valid;
    end

    // at most one cell reports an insert point or a read hit
    always_comb begin
        w_rank_or = '0;
        w_rd_or   = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_rank_or = w_rank_or | w_rank[i];
            w_rd_or   = w_rd_or | w_rd[i];
        end
    end

    always_comb begin
        n_sum   = r_sum;
        n_worst = r_worst;
        if (w_evict) begin
            n_sum = r_sum - SUM_W'(w_entry[TABLE_DEPTH-1].cost) + SUM_W'(r_cost);
            n_worst = w_gt[TABLE_DEPTH-2] ? w_entry[TABLE_DEPTH-2].cost : r_cost;
        end else if (w_acc) begin
            n_sum = r_sum + SUM_W'(r_cost);
            n_worst = (!w_entry[0].valid || (r_cost >= r_worst)) ? r_cost : r_worst;
        end
        if (w_acc) begin
            n_best = w_gt[0] ? r_cost : w_entry[0].cost;
        end else begin
            n_best = w_entry[0].valid ? w_entry[0].cost : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            o_valid <= 1'b0;
            r_sum   <= '0;
            r_worst <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_busy       <= 1'b1;
                r_req_type   <= i_req_type;
                r_cost       <= i_candidate_cost;
                r_handle     <= i_candidate_handle;
                r_rank_index <= i_rank_index;
            end else if (w_go) begin
                r_busy <= 1'b0;
            end
            if (w_go) begin
                o_valid          <= 1'b1;
                r_sum            <= n_sum;
                r_worst          <= n_worst;
                o_accepted       <= w_acc;
                o_insert_rank    <= w_acc ? w_rank_or : '0;
                o_evicted_valid  <= w_evict;
                o_evicted_handle <= w_evict ? w_entry[TABLE_DEPTH-1].handle :
                                    ((w_is_ins && !w_acc) ? r_handle : '0);
                o_rank_valid     <= !w_is_ins && w_rd_or.valid;
                o_rank_handle    <= w_is_ins ? '0 : w_rd_or.handle;
                o_rank_cost      <= w_is_ins ? '0 : w_rd_or.cost;
                o_best_cost      <= n_best;
                o_worst_cost     <= n_worst;
                o_cost_sum       <= n_sum;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    `SBNT_ASSERT(a_valid_prefix, $onehot({1'b0, w_vld} + 1'b1), "valid cells are not a prefix")
    `SBNT_ASSERT(a_best_le_worst, o_valid |-> (o_best_cost <= o_worst_cost), "best above worst")
    `SBNT_ASSERT(a_reject_no_evict, (o_valid && !o_accepted) |-> !o_evicted_valid, "eviction on reject")
    `SBNT_ASSERT(a_busy_holds, (r_busy && o_valid && !i_ready) |=> r_busy, "request dropped on stall")

endmodule

[sim/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbnt_pkg::*;

    localparam int TABLE_DEPTH    = 256;
    localparam int CLK_PERIOD     = 20;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int LONG_HOLD      = 400;
    localparam int TIMEOUT_CYCLES = 300000;

    typedef enum int {RX_STEADY, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} t_rx_mode;

    typedef struct packed {
        logic                accepted;
        logic [RANK_W-1:0]   insert_rank;
        logic                evicted_valid;
        logic [HANDLE_W-1:0] evicted_handle;
        logic                rank_valid;
        logic [HANDLE_W-1:0] rank_handle;
        logic [COST_W-1:0]   rank_cost;
        logic [COST_W-1:0]   best_cost;
        logic [COST_W-1:0]   worst_cost;
        logic [SUM_W-1:0]    cost_sum;
    } t_table_result;

    // mirror of the ranked table plus the queue of results still owed by the block
    class t_best_n_tracker;
        logic [COST_W-1:0]   costs [TABLE_DEPTH];
        logic [HANDLE_W-1:0] handles [TABLE_DEPTH];
        int                  fill;
        logic [SUM_W-1:0]    sum;
        t_table_result       pending_results [$];
        int                  errors;
        int                  results_checked;

        function new();
            fill            = 0;
            sum             = '0;
            errors          = 0;
            results_checked = 0;
        endfunction

        function logic [COST_W-1:0] worst_cost();
            return (fill == 0) ? '0 : costs[fill-1];
        endfunction

        function void note_request(logic req, logic [COST_W-1:0] cost,
                                   logic [HANDLE_W-1:0] hdl, logic [RANK_W-1:0] rank);
            t_table_result       r;
            int                  pos;
            logic [COST_W-1:0]   tmp_cost;
            logic [HANDLE_W-1:0] tmp_handle;
            r   = '0;
            pos = -1;
            if (req == REQ_INSERT) begin
                if (fill < TABLE_DEPTH) begin
                    pos  = fill;
                    fill = fill + 1;
                    sum  = sum + cost;
                end else if (cost < costs[TABLE_DEPTH-1]) begin
                    pos              = TABLE_DEPTH - 1;
                    r.evicted_valid  = 1'b1;
                    r.evicted_handle = handles[pos];
                    sum              = sum - costs[pos] + cost;
                end else begin
                    r.evicted_handle = hdl;
                end
                if (pos >= 0) begin
                    costs[pos]   = cost;
                    handles[pos] = hdl;
                    // bubble past strictly dearer entries so ties keep arrival order
                    while (pos > 0 && costs[pos-1] > costs[pos]) begin
                        tmp_cost       = costs[pos-1];
                        tmp_handle     = handles[pos-1];
                        costs[pos-1]   = costs[pos];
                        handles[pos-1] = handles[pos];
                        costs[pos]     = tmp_cost;
                        handles[pos]   = tmp_handle;
                        pos--;
                    end
                    r.accepted    = 1'b1;
                    r.insert_rank = pos[RANK_W-1:0];
                end
            end else if (int'(rank) < fill) begin
                r.rank_valid  = 1'b1;
                r.rank_handle = handles[rank];
                r.rank_cost   = costs[rank];
            end
            if (fill > 0) begin
                r.best_cost  = costs[0];
                r.worst_cost = costs[fill-1];
            end
            r.cost_sum = sum;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_table_result got);
            t_table_result want;
            results_checked++;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("accepted", 64'(want.accepted), 64'(got.accepted));
            compare_field("insert_rank", 64'(want.insert_rank), 64'(got.insert_rank));
            compare_field("evicted_valid", 64'(want.evicted_valid), 64'(got.evicted_valid));
            compare_field("evicted_handle", 64'(want.evicted_handle),
                          64'(got.evicted_handle));
            compare_field("rank_valid", 64'(want.rank_valid), 64'(got.rank_valid));
            compare_field("rank_handle", 64'(want.rank_handle), 64'(got.rank_handle));
            compare_field("rank_cost", 64'(want.rank_cost), 64'(got.rank_cost));
            compare_field("best_cost", 64'(want.best_cost), 64'(got.best_cost));
            compare_field("worst_cost", 64'(want.worst_cost), 64'(got.worst_cost));
            compare_field("cost_sum", 64'(want.cost_sum), 64'(got.cost_sum));
        endfunction
    endclass

    logic                i_clk              = 1'b0;
    logic                i_rst_n            = 1'b0;
    logic                i_valid            = 1'b0;
    logic                i_req_type         = REQ_INSERT;
    logic [COST_W-1:0]   i_candidate_cost   = '0;
    logic [HANDLE_W-1:0] i_candidate_handle = '0;
    logic [RANK_W-1:0]   i_rank_index       = '0;
    logic                i_ready            = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic                o_accepted;
    logic [RANK_W-1:0]   o_insert_rank;
    logic                o_evicted_valid;
    logic [HANDLE_W-1:0] o_evicted_handle;
    logic                o_rank_valid;
    logic [HANDLE_W-1:0] o_rank_handle;
    logic [COST_W-1:0]   o_rank_cost;
    logic [COST_W-1:0]   o_best_cost;
    logic [COST_W-1:0]   o_worst_cost;
    logic [SUM_W-1:0]    o_cost_sum;

    t_best_n_tracker tracker = new();

    sorted_best_n_table_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_req_type         (i_req_type),
        .i_candidate_cost   (i_candidate_cost),
        .i_candidate_handle (i_candidate_handle),
        .i_rank_index       (i_rank_index),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_accepted         (o_accepted),
        .o_insert_rank      (o_insert_rank),
        .o_evicted_valid    (o_evicted_valid),
        .o_evicted_handle   (o_evicted_handle),
        .o_rank_valid       (o_rank_valid),
        .o_rank_handle      (o_rank_handle),
        .o_rank_cost        (o_rank_cost),
        .o_best_cost        (o_best_cost),
        .o_worst_cost       (o_worst_cost),
        .o_cost_sum         (o_cost_sum)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // holds the beat until the block takes it, then books the expected result
    task automatic send_request(input logic req, input logic [COST_W-1:0] cost,
                                input logic [HANDLE_W-1:0] hdl,
                                input logic [RANK_W-1:0] rank);
        i_valid            <= 1'b1;
        i_req_type         <= req;
        i_candidate_cost   <= cost;
        i_candidate_handle <= hdl;
        i_rank_index       <= rank;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_request(req, cost, hdl, rank);
    endtask

    // costs lean towards the eviction boundary and towards ties
    function automatic void draw_request(output logic req, output logic [COST_W-1:0] cost,
                                         output logic [HANDLE_W-1:0] hdl,
                                         output logic [RANK_W-1:0] rank);
        logic [COST_W-1:0] worst;
        int                used;
        used  = tracker.fill;
        worst = tracker.worst_cost();
        req   = ($urandom_range(0, 99) < ((used < TABLE_DEPTH) ? 85 : 65)) ? REQ_INSERT
                                                                           : REQ_READ;
        hdl   = HANDLE_W'($urandom_range(0, (1 << HANDLE_W) - 1));
        if (used > 0 && $urandom_range(0, 1) == 1)
            rank = RANK_W'($urandom_range(0, used - 1));
        else
            rank = RANK_W'($urandom_range(0, (1 << RANK_W) - 1));
        case ($urandom_range(0, 9))
            0, 1, 2: cost = $urandom;
            3, 4:    cost = (worst == 0) ? '0 : $urandom_range(0, worst - 1);
            5:       cost = worst;
            6:       cost = (worst == 0) ? '0 : worst - 1;
            7:       cost = $urandom_range(0, 15);
            8:       cost = ($urandom_range(0, 1) == 1) ? '1 : '0;
            default: cost = (used > 0) ? tracker.costs[$urandom_range(0, used - 1)] : $urandom;
        endcase
    endfunction

    initial begin
        int                  sent;
        int                  burst;
        int                  gap;
        int                  k;
        logic                req;
        logic [COST_W-1:0]   cost;
        logic [HANDLE_W-1:0] hdl;
        logic [RANK_W-1:0]   rank;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, extremes, ties and out-of-range ranks
        send_request(REQ_READ, '1, '1, 8'd0);
        send_request(REQ_READ, '0, '0, 8'd255);
        send_request(REQ_INSERT, '1, 9'd511, 8'd255);
        send_request(REQ_INSERT, '0, 9'd0, 8'd0);
        send_request(REQ_INSERT, 32'd100, 9'd1, 8'd17);
        send_request(REQ_INSERT, 32'd100, 9'd2, 8'd3);
        send_request(REQ_INSERT, 32'd100, 9'd3, 8'd0);
        send_request(REQ_INSERT, 32'd50, 9'd4, 8'd1);
        send_request(REQ_INSERT, '1, 9'd5, 8'd2);
        send_request(REQ_INSERT, 32'h8000_0000, 9'h0AA, 8'd9);
        send_request(REQ_INSERT, 32'h7FFF_FFFF, 9'h155, 8'd4);
        send_request(REQ_INSERT, 32'hAAAA_AAAA, 9'd6, 8'd8);
        send_request(REQ_INSERT, 32'h5555_5555, 9'd7, 8'd5);
        send_request(REQ_READ, '0, '0, 8'd0);
        send_request(REQ_READ, '0, '0, 8'd2);
        send_request(REQ_READ, '0, '0, 8'd3);
        send_request(REQ_READ, '0, '0, 8'd4);
        send_request(REQ_READ, '0, '0, 8'd10);
        send_request(REQ_READ, '0, '0, 8'd11);
        send_request(REQ_READ, '1, '1, 8'd255);
        i_valid <= 1'b0;
        repeat (3) @(posedge i_clk);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 40);
            for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                draw_request(req, cost, hdl, rank);
                send_request(req, cost, hdl, rank);
                sent++;
                if (sent == RANDOM_ITEMS / 2) begin
                    // let the pipe run dry before carrying on
                    i_valid <= 1'b0;
                    do @(posedge i_clk); while (tracker.pending_results.size() != 0);
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (gap == 0)
            i_valid <= 1'b0;

        while (tracker.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // receiver back-pressure, with one long hold-off once results are flowing
    initial begin
        t_rx_mode mode;
        int       span;
        int       k;
        bit       long_hold_done;
        long_hold_done = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!long_hold_done && tracker.results_checked >= 300) begin
                long_hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(8, 64);
            for (k = 0; k < span; k++) begin
                case (mode)
                    RX_STEADY: i_ready <= 1'b1;
                    RX_MOSTLY: i_ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_ready <= k[0];
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_table_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.accepted       = o_accepted;
            got.insert_rank    = o_insert_rank;
            got.evicted_valid  = o_evicted_valid;
            got.evicted_handle = o_evicted_handle;
            got.rank_valid     = o_rank_valid;
            got.rank_handle    = o_rank_handle;
            got.rank_cost      = o_rank_cost;
            got.best_cost      = o_best_cost;
            got.worst_cost     = o_worst_cost;
            got.cost_sum       = o_cost_sum;
            tracker.check_result(got);
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("TEST FAILED");
        $finish;
    end

endmodule
